FILE: rtl/core/jdc_pkg.sv
package jdc_pkg;

    // Request kinds carried on tuser
    typedef enum logic [1:0] {
        REQ_DAY_TO_DATE = 2'd0,
        REQ_DATE_TO_DAY = 2'd1,
        REQ_HOURS       = 2'd2,
        REQ_NONE        = 2'd3
    } t_req;

    // Load enables for the datapath stages, one per datapath register stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_ld;

    // Field widths
    localparam int unsigned DN_W    = 23;
    localparam int unsigned YEAR_W  = 15;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOURS_W = 27;
    localparam int unsigned HOUR_W  = 5;

    // Range limits and epoch
    localparam logic [DN_W-1:0]    JDN_MAX         = 23'd5373484;
    localparam logic [HOURS_W-1:0] HOURS_MAX       = 27'd87649463;
    localparam logic [DN_W-1:0]    HOURS_EPOCH_DAY = 23'd1721424;

    // Constant dividers: q = (n * M) >> SH, exact for n below 2**N, with
    // SH = N + ceil(log2(D)) and M = ceil(2**SH / D).

    // n / 3, n < 2**24 (hours / 8 / 3)
    localparam int unsigned    DIV3_SH = 26;
    localparam logic [24:0]    DIV3_M  = 25'(((64'd1 << DIV3_SH) + 64'd2) / 64'd3);

    // n / 146097, n < 2**25
    localparam int unsigned    DIVA_SH = 43;
    localparam logic [25:0]    DIVA_M  =
        26'(((64'd1 << DIVA_SH) + 64'd146096) / 64'd146097);

    // n / 1461, n < 2**25
    localparam int unsigned    DIVE_SH = 36;
    localparam logic [25:0]    DIVE_M  = 26'(((64'd1 << DIVE_SH) + 64'd1460) / 64'd1461);

    // n / 100 and n / 400, n < 2**16; both reciprocals round up to the same
    // multiplier, so one product serves both
    localparam int unsigned    DIV100_SH = 23;
    localparam int unsigned    DIV400_SH = 25;
    localparam logic [16:0]    YDIV_M    =
        17'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);

    // n / 153, n < 2**11
    localparam int unsigned    DIV153_SH = 19;
    localparam logic [11:0]    DIV153_M  =
        12'(((64'd1 << DIV153_SH) + 64'd152) / 64'd153);

    // n / 5, n < 2**8
    localparam int unsigned    DIV5_SH = 11;
    localparam logic [8:0]     DIV5_M  = 9'(((64'd1 << DIV5_SH) + 64'd4) / 64'd5);

    // Year offset that makes the shifted year positive (multiple of 400)
    localparam logic signed [16:0] YEAR_BIAS = 17'sd16800;
    // Collected constant of the date to day number sum
    localparam logic signed [25:0] JDN_BIAS  = 26'sd4414955;

    // Days before the shifted month (March based): (153 * mm + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] mm);
        logic [8:0] v;
        unique case (mm)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/julian_day_calendar_converter_top.sv
// Converts between Julian Day Numbers, proleptic Gregorian dates and hours
// since the AD epoch. One item is accepted every clock cycle unless all stages
// hold items and the output is stalled. The item passes an input register,
// five datapath stages (each holding one constant multiply of the day-to-date
// chain; the date-to-day chain multiplies in the first two) and the output
// register. Stages holding no item are filled while the output is stalled, so
// the slave side drops tready only once all seven stages hold items.
module julian_day_calendar_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: day_number_in[22:0], year_in[37:23], month_in[41:38],
    //        day_in[46:42], hours_since_epoch[73:47], zero pad [79:74]
    input  logic [79:0] i_s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: year_out[14:0], month_out[18:15], day_out[23:19], hour_out[28:24],
    //        day_number_out[51:29], input_clamped[52], zero pad [55:53]
    output logic [55:0] o_m_axis_tdata
);
    import jdc_pkg::*;

    localparam int unsigned NSTG = 7;

    // Stage load enables: a stage loads when empty or when it moves on
    logic [NSTG-1:0] ld;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    t_stage_ld       stg_ld;

    always_comb begin
        ld[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        n_vld[0] = ld[0] ? i_s_axis_tvalid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = ld[k] ? r_vld[k-1] : r_vld[k];
        end
        stg_ld.s1 = ld[1];
        stg_ld.s2 = ld[2];
        stg_ld.s3 = ld[3];
        stg_ld.s4 = ld[4];
        stg_ld.s5 = ld[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = ld[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];

    // Input register and request kind along the stages
    logic [DN_W-1:0]          r_dn_in;
    logic signed [YEAR_W-1:0] r_year_in;
    logic [MON_W-1:0]         r_mon_in;
    logic [DAY_W-1:0]         r_day_in;
    logic [HOURS_W-1:0]       r_hrs_in;
    t_req                     r_kind [NSTG-1];

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_dn_in   <= i_s_axis_tdata[22:0];
            r_year_in <= i_s_axis_tdata[37:23];
            r_mon_in  <= i_s_axis_tdata[41:38];
            r_day_in  <= i_s_axis_tdata[46:42];
            r_hrs_in  <= i_s_axis_tdata[73:47];
            r_kind[0] <= t_req'(i_s_axis_tuser);
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (ld[k]) begin
                r_kind[k] <= r_kind[k-1];
            end
        end
    end

    // Datapath
    logic [DN_W-1:0]          fr_j;
    logic [7:0]               fr_a;
    logic [HOUR_W-1:0]        fr_hour;
    logic signed [YEAR_W-1:0] sp_year;
    logic [MON_W-1:0]         sp_month;
    logic [DAY_W-1:0]         sp_day;
    logic [HOUR_W-1:0]        sp_hour;
    logic [DN_W-1:0]          en_dn;
    logic                     en_clamped;

    jdc_day_front u_front (
        .i_clk        (i_clk),
        .i_ld         (stg_ld),
        .i_kind_s1    (r_kind[1]),
        .i_day_number (r_dn_in),
        .i_hours      (r_hrs_in),
        .o_j          (fr_j),
        .o_a          (fr_a),
        .o_hour       (fr_hour)
    );

    jdc_day_split u_split (
        .i_clk   (i_clk),
        .i_ld    (stg_ld),
        .i_j     (fr_j),
        .i_a     (fr_a),
        .i_hour  (fr_hour),
        .o_year  (sp_year),
        .o_month (sp_month),
        .o_day   (sp_day),
        .o_hour  (sp_hour)
    );

    jdc_date_encode u_encode (
        .i_clk        (i_clk),
        .i_ld         (stg_ld),
        .i_year       (r_year_in),
        .i_month      (r_mon_in),
        .i_day        (r_day_in),
        .o_day_number (en_dn),
        .o_clamped    (en_clamped)
    );

    // Output register: select fields by request kind, zero the rest
    logic signed [YEAR_W-1:0] n_year,  r_year;
    logic [MON_W-1:0]         n_month, r_month;
    logic [DAY_W-1:0]         n_day,   r_day;
    logic [HOUR_W-1:0]        n_hour,  r_hour;
    logic [DN_W-1:0]          n_dn,    r_dn;
    logic                     n_clamp, r_clamp;

    always_comb begin
        n_year  = '0;
        n_month = '0;
        n_day   = '0;
        n_hour  = '0;
        n_dn    = '0;
        n_clamp = 1'b0;
        unique case (r_kind[NSTG-2])
            REQ_DAY_TO_DATE: begin
                n_year  = sp_year;
                n_month = sp_month;
                n_day   = sp_day;
            end
            REQ_DATE_TO_DAY: begin
                n_dn    = en_dn;
                n_clamp = en_clamped;
            end
            REQ_HOURS: begin
                n_year  = sp_year;
                n_month = sp_month;
                n_day   = sp_day;
                n_hour  = sp_hour;
            end
            REQ_NONE: begin
                n_clamp = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld[NSTG-1]) begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_dn    <= n_dn;
            r_clamp <= n_clamp;
        end
    end

    assign o_m_axis_tdata = {3'b000, r_clamp, r_dn, r_hour, r_day, r_month, r_year};

    // Checks
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |-> o_s_axis_tready)
        else $error("empty pipeline not ready");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted item lost at input register");

    a_clamp_no_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[52]) |->
        (o_m_axis_tdata[23:0] == 24'd0))
        else $error("clamp flag with date fields set");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[18:15] != 4'd0)) |->
        ((o_m_axis_tdata[18:15] <= 4'd12) && (o_m_axis_tdata[23:19] != 5'd0)))
        else $error("month or day out of range");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[28:24] <= 5'd23))
        else $error("hour of day out of range");

endmodule

FILE: rtl/core/jdc_day_front.sv
module jdc_day_front (
    input  logic                         i_clk,
    input  jdc_pkg::t_stage_ld           i_ld,
    input  jdc_pkg::t_req                i_kind_s1,
    input  logic [jdc_pkg::DN_W-1:0]     i_day_number,
    input  logic [jdc_pkg::HOURS_W-1:0]  i_hours,
    output logic [jdc_pkg::DN_W-1:0]     o_j,
    output logic [7:0]                   o_a,
    output logic [jdc_pkg::HOUR_W-1:0]   o_hour
);
    import jdc_pkg::*;

    // Stage 1: clamp inputs, hours / 24 as (hours >> 3) / 3
    logic [DN_W-1:0]    n_j0;
    logic [HOURS_W-1:0] hrs_c;
    logic [23:0]        n_x;
    logic [48:0]        p3;
    logic [21:0]        n_q3;

    logic [DN_W-1:0]    r_j0;
    logic [23:0]        r_x;
    logic [21:0]        r_q3;
    logic [2:0]         r_lo3;

    always_comb begin
        n_j0  = (i_day_number > JDN_MAX) ? JDN_MAX : i_day_number;
        hrs_c = (i_hours > HOURS_MAX) ? HOURS_MAX : i_hours;
        n_x   = hrs_c[HOURS_W-1:3];
        p3    = 49'(n_x) * 49'(DIV3_M);
        n_q3  = p3[DIV3_SH +: 22];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r_j0  <= n_j0;
            r_x   <= n_x;
            r_q3  <= n_q3;
            r_lo3 <= hrs_c[2:0];
        end
    end

    // Stage 2: pick day number, hour of day, century term a
    logic [23:0]     rem3;
    logic [DN_W-1:0] n_j;
    logic [24:0]     n_arg;
    logic [50:0]     pa;
    logic [HOUR_W-1:0] n_hour;

    logic [DN_W-1:0]   r_j;
    logic [7:0]        r_a;
    logic [HOUR_W-1:0] r_hour;

    always_comb begin
        rem3   = r_x - 24'({r_q3, 1'b0}) - 24'(r_q3);
        n_hour = {rem3[1:0], r_lo3};
        n_j    = (i_kind_s1 == REQ_HOURS) ? (HOURS_EPOCH_DAY + 23'(r_q3)) : r_j0;
        n_arg  = {n_j, 2'b00} + 25'd274277;
        pa     = 51'(n_arg) * 51'(DIVA_M);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r_j    <= n_j;
            r_a    <= pa[DIVA_SH +: 8];
            r_hour <= n_hour;
        end
    end

    assign o_j    = r_j;
    assign o_a    = r_a;
    assign o_hour = r_hour;

endmodule

FILE: rtl/core/jdc_date_encode.sv
module jdc_date_encode (
    input  logic                               i_clk,
    input  jdc_pkg::t_stage_ld                 i_ld,
    input  logic signed [jdc_pkg::YEAR_W-1:0]  i_year,
    input  logic [jdc_pkg::MON_W-1:0]          i_month,
    input  logic [jdc_pkg::DAY_W-1:0]          i_day,
    output logic [jdc_pkg::DN_W-1:0]           o_day_number,
    output logic                               o_clamped
);
    import jdc_pkg::*;

    // Stage 1: clamp month and day, shift year to March based, year / 100, / 400
    logic [MON_W-1:0]   m_c;
    logic [DAY_W-1:0]   d_c;
    logic               early;
    logic               n_clamp;
    logic signed [16:0] ys;
    logic [15:0]        n_yy;
    logic [3:0]         mm;
    logic [9:0]         n_dsum;
    logic [32:0]        py;

    logic [15:0] r_yy;
    logic [8:0]  r_q100;
    logic [6:0]  r_q400;
    logic [9:0]  r_dsum;
    logic        r_cl1;

    always_comb begin
        if (i_month == '0) begin
            m_c = 4'd1;
        end else if (i_month > 4'd12) begin
            m_c = 4'd12;
        end else begin
            m_c = i_month;
        end
        d_c     = (i_day == '0) ? 5'd1 : i_day;
        n_clamp = (i_month == '0) || (i_month > 4'd12) || (i_day == '0);
        early   = (m_c <= 4'd2);
        ys      = $signed({{2{i_year[YEAR_W-1]}}, i_year}) + YEAR_BIAS
                  - $signed({16'd0, early});
        n_yy    = ys[15:0];
        mm      = early ? (m_c + 4'd9) : (m_c - 4'd3);
        n_dsum  = 10'(d_c) + 10'(month_offset(mm));
        py      = 33'(n_yy) * 33'(YDIV_M);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r_yy   <= n_yy;
            r_q100 <= py[DIV100_SH +: 9];
            r_q400 <= py[DIV400_SH +: 7];
            r_dsum <= n_dsum;
            r_cl1  <= n_clamp;
        end
    end

    // Stage 2: day number sum and saturation
    logic [23:0]        y365;
    logic signed [25:0] sum;
    logic [DN_W-1:0]    n_dn;

    logic [DN_W-1:0] r_dn [3];
    logic            r_cl [3];

    always_comb begin
        y365 = 24'(r_yy) * 24'd365;
        sum  = $signed({2'b00, y365}) + $signed({12'd0, r_yy[15:2]})
               - $signed({17'd0, r_q100}) + $signed({19'd0, r_q400})
               + $signed({16'd0, r_dsum}) - JDN_BIAS;
        if (sum < 26'sd0) begin
            n_dn = '0;
        end else if (sum > $signed({3'b000, JDN_MAX})) begin
            n_dn = JDN_MAX;
        end else begin
            n_dn = sum[DN_W-1:0];
        end
    end

    // Stage 2 register, then delay to line up with the date split
    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r_dn[0] <= n_dn;
            r_cl[0] <= r_cl1;
        end
        if (i_ld.s3) begin
            r_dn[1] <= r_dn[0];
            r_cl[1] <= r_cl[0];
        end
        if (i_ld.s4) begin
            r_dn[2] <= r_dn[1];
            r_cl[2] <= r_cl[1];
        end
    end

    logic [DN_W-1:0] r_dn5;
    logic            r_cl5;

    always_ff @(posedge i_clk) begin
        if (i_ld.s5) begin
            r_dn5 <= r_dn[2];
            r_cl5 <= r_cl[2];
        end
    end

    assign o_day_number = r_dn5;
    assign o_clamped    = r_cl5;

endmodule

FILE: rtl/core/jdc_day_split.sv
module jdc_day_split (
    input  logic                               i_clk,
    input  jdc_pkg::t_stage_ld                 i_ld,
    input  logic [jdc_pkg::DN_W-1:0]           i_j,
    input  logic [7:0]                         i_a,
    input  logic [jdc_pkg::HOUR_W-1:0]         i_hour,
    output logic signed [jdc_pkg::YEAR_W-1:0]  o_year,
    output logic [jdc_pkg::MON_W-1:0]          o_month,
    output logic [jdc_pkg::DAY_W-1:0]          o_day,
    output logic [jdc_pkg::HOUR_W-1:0]         o_hour
);
    import jdc_pkg::*;

    // Stage 3: f = j + 1363 + 3a/4, e = 4f + 3, e / 1461
    logic [9:0]  a3;
    logic [22:0] f;
    logic [24:0] n_e;
    logic [50:0] pe;

    logic [24:0]       r_e3;
    logic [13:0]       r_qe3;
    logic [HOUR_W-1:0] r_hr3;

    always_comb begin
        a3  = 10'({i_a, 1'b0}) + 10'(i_a);
        f   = i_j + 23'd1363 + 23'(a3[9:2]);
        n_e = {f, 2'b11};
        pe  = 51'(n_e) * 51'(DIVE_M);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            r_e3  <= n_e;
            r_qe3 <= pe[DIVE_SH +: 14];
            r_hr3 <= i_hour;
        end
    end

    // Stage 4: day of the shifted year g = (e mod 1461) / 4
    logic [24:0] erem;

    logic [8:0]        r_g4;
    logic [13:0]       r_qe4;
    logic [HOUR_W-1:0] r_hr4;

    always_comb begin
        erem = r_e3 - 25'(r_qe3) * 25'd1461;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s4) begin
            r_g4  <= erem[10:2];
            r_qe4 <= r_qe3;
            r_hr4 <= r_hr3;
        end
    end

    // Stage 5: h = 5g + 2, shifted month h / 153
    logic [10:0] n_h;
    logic [22:0] ph;

    logic [10:0]       r_h5;
    logic [3:0]        r_mh5;
    logic [13:0]       r_qe5;
    logic [HOUR_W-1:0] r_hr5;

    always_comb begin
        n_h = {r_g4, 2'b00} + 11'(r_g4) + 11'd2;
        ph  = 23'(n_h) * 23'(DIV153_M);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s5) begin
            r_h5  <= n_h;
            r_mh5 <= ph[DIV153_SH +: 4];
            r_qe5 <= r_qe4;
            r_hr5 <= r_hr4;
        end
    end

    // Final: day, month and year, fed to the output register
    logic [10:0]        hrem;
    logic [16:0]        pd;
    logic [MON_W-1:0]   mon;
    logic signed [15:0] y16;

    always_comb begin
        hrem = r_h5 - 11'(r_mh5) * 11'd153;
        pd   = 17'(hrem[7:0]) * 17'(DIV5_M);
        mon  = (r_mh5 < 4'd10) ? (r_mh5 + 4'd3) : (r_mh5 - 4'd9);
        y16  = $signed({2'b00, r_qe5}) - 16'sd4716
               + $signed({15'd0, (mon <= 4'd2)});
    end

    assign o_day   = pd[DIV5_SH +: 5] + 5'd1;
    assign o_month = mon;
    assign o_year  = y16[YEAR_W-1:0];
    assign o_hour  = r_hr5;

endmodule
